>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iqc_pkg.sv
`default_nettype none
package iqc_pkg;

  typedef enum logic [1:0] {
    CFG_DIRECTION   = 2'd0,
    CFG_FORMAT      = 2'd1,
    CFG_HOST_BIG    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    FMT_FLOAT32 = 2'd0,
    FMT_INT16   = 2'd1,
    FMT_CUSTOM  = 2'd2,
    FMT_UNSUP   = 2'd3
  } sample_format_e;

  localparam int unsigned Q15_FRAC_BITS = 15;
  localparam int unsigned HALF_WIDTH    = 16;

  typedef struct packed {
    logic [31:0] in_word_a;
    logic [31:0] in_word_b;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;
    logic        last_out;
    logic        format_error;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/iq_sample_format_converter.sv
// Three register stages lie between input transfer and result valid.
// Throughput: one sample per cycle; the stage chain stalls as a whole only when
// the output is not taken, so a full pipeline still accepts while results move.
// Reset: rst_ni clears all valid bits and the configuration registers to zero
// (host to wire, complex float32, little-endian host).
`default_nettype none
`include "assert_macros.svh"
module iq_sample_format_converter
  import iqc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  // Configuration registers.
  logic           dir_q;
  sample_format_e fmt_q;
  logic           hbe_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      fmt_q <= FMT_FLOAT32;
      hbe_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_DIRECTION: dir_q <= cfg_data_i[0];
        CFG_FORMAT:    fmt_q <= sample_format_e'(cfg_data_i[1:0]);
        CFG_HOST_BIG:  hbe_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together when the output stage can move.
  logic v1_q, v2_q, v3_q;
  logic adv;
  assign adv        = !v3_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- Stage 1: field decode ----------------
  // Float to Q15 decode: classify and compute shift amount per lane.
  typedef struct packed {
    logic        zero;
    logic        sat;
    logic        neg;
    logic [4:0]  sh;
    logic [23:0] man;
  } f2q_t;

  function automatic f2q_t f2q_decode(input logic [31:0] b);
    f2q_t r;
    logic [7:0] ex;
    logic [7:0] shw;
    ex = b[30:23];
    r.neg = b[31];
    r.man = {1'b1, b[22:0]};
    r.sat = 1'b0;
    r.zero = 1'b0;
    shw = 8'd135 - ex;
    r.sh = shw[4:0];
    if (ex == 8'hFF && b[22:0] != 23'd0) r.zero = 1'b1;
    else if (ex == 8'd0) r.zero = 1'b1;
    else if (ex >= 8'd127) r.sat = 1'b1;
    else if (shw >= 8'd24) r.zero = 1'b1;
    return r;
  endfunction

  // Q15 to float decode: sign and magnitude of each half.
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } q2f_t;

  function automatic q2f_t q2f_decode(input logic [15:0] h);
    q2f_t r;
    r.neg = h[15];
    r.mag = h[15] ? (16'd0 - h) : h;
    return r;
  endfunction

  f2q_t     s1_fa_q, s1_fb_q;
  q2f_t     s1_qa_q, s1_qb_q;
  logic [31:0] s1_word_q;
  logic     s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_fa_q   <= f2q_decode(in_data_i.in_word_a);
      s1_fb_q   <= f2q_decode(in_data_i.in_word_b);
      s1_qa_q   <= q2f_decode(in_data_i.in_word_a[31:16]);
      s1_qb_q   <= q2f_decode(in_data_i.in_word_a[15:0]);
      s1_word_q <= in_data_i.in_word_a;
      s1_last_q <= in_data_i.last_sample;
    end
  end

  // ---------------- Stage 2: shift and normalize ----------------
  function automatic logic [15:0] f2q_finish(input f2q_t f);
    logic [23:0] m;
    m = f.man >> f.sh;
    if (f.zero) return 16'd0;
    if (f.sat)  return f.neg ? 16'h8000 : 16'h7FFF;
    return f.neg ? (16'd0 - m[15:0]) : m[15:0];
  endfunction

  // Leading-one position, used to normalize the magnitude.
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [3:0]  msb;
    logic [15:0] mag;
  } q2n_t;

  function automatic q2n_t q2f_norm(input q2f_t q);
    q2n_t r;
    r.neg  = q.neg;
    r.mag  = q.mag;
    r.zero = (q.mag == 16'd0);
    r.msb  = 4'd0;
    for (int i = 0; i < HALF_WIDTH; i++) begin
      if (q.mag[i]) r.msb = 4'(i);
    end
    return r;
  endfunction

  logic [15:0] s2_ra_q, s2_rb_q;
  q2n_t        s2_na_q, s2_nb_q;
  logic [31:0] s2_word_q;
  logic        s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ra_q   <= f2q_finish(s1_fa_q);
      s2_rb_q   <= f2q_finish(s1_fb_q);
      s2_na_q   <= q2f_norm(s1_qa_q);
      s2_nb_q   <= q2f_norm(s1_qb_q);
      s2_word_q <= s1_word_q;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------- Stage 3: pack and select ----------------
  // Exact float of mag * 2^-15: exponent 127 - 15 + msb, mantissa left-aligned.
  function automatic logic [31:0] q2f_pack(input q2n_t n);
    logic [31:0] sh;
    logic [7:0]  ex;
    if (n.zero) return 32'd0;
    sh = {16'd0, n.mag} << (5'd23 - {1'b0, n.msb});
    ex = 8'(127 - Q15_FRAC_BITS) + {4'd0, n.msb};
    return {n.neg, ex, sh[22:0]};
  endfunction

  out_item_t res;
  always_comb begin
    res = '0;
    res.last_out = s2_last_q;
    unique case (fmt_q)
      FMT_FLOAT32: begin
        if (!dir_q) begin
          res.out_word_a = {s2_ra_q, s2_rb_q};
        end else begin
          res.out_word_a = q2f_pack(s2_na_q);
          res.out_word_b = q2f_pack(s2_nb_q);
        end
      end
      FMT_INT16: begin
        res.out_word_a = hbe_q ? s2_word_q :
          {s2_word_q[7:0], s2_word_q[15:8], s2_word_q[23:16], s2_word_q[31:24]};
      end
      FMT_CUSTOM: res.out_word_a = s2_word_q;
      default:    res.format_error = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_o <= res;
  end

  assign out_valid_o = v3_q;

  // Checks on pipeline bookkeeping.
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, v3_q && !out_ready_i, v3_q && $stable(out_data_o),
    "stalled result changed")
  `ASSERT_NEXT(a_v2_moves, clk_i, rst_ni, v2_q && adv, v3_q, "stage two item lost")
  `ASSERT_ALWAYS(a_err_zero, clk_i, rst_ni,
    !(v3_q && out_data_o.format_error) || (out_data_o.out_word_a == 32'd0 &&
    out_data_o.out_word_b == 32'd0), "error result carries data")

endmodule
`default_nettype wire

>>> tb/iq_sample_format_converter_tb.sv
`default_nettype none
module iq_sample_format_converter_tb;
  import iqc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic           dir_q = 1'b0;
  sample_format_e fmt_q = FMT_FLOAT32;
  logic           big_q = 1'b0;

  out_item_t expected_q[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  logic        hold_active = 1'b0;
  event        hold_start;
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;

  always #1 clk = ~clk;

  iq_sample_format_converter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Float bits to a Q15 half, scaled by 2^15 and truncated toward zero.
  function automatic logic [15:0] float_to_q15(logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] mant;
    logic [31:0] mag;
    int unsigned sh;
    ex = b[30:23];
    mant = {1'b1, b[22:0]};
    if (ex == 8'hFF && b[22:0] != 0) return 16'h0000;
    if (ex == 8'h00) return 16'h0000;
    if (ex >= 8'd127) return b[31] ? 16'h8000 : 16'h7FFF;
    sh = 135 - ex;
    if (sh >= 24) return 16'h0000;
    mag = 32'(mant) >> sh;
    return b[31] ? 16'(-mag) : mag[15:0];
  endfunction

  // Q15 half to the exact float bits of its value times 2^-15.
  function automatic logic [31:0] q15_to_float(logic [15:0] h);
    logic [31:0] m;
    int p;
    if (h == 16'h0000) return 32'h0;
    m = h[15] ? (32'h10000 - 32'(h)) : 32'(h);
    p = 0;
    for (int i = 0; i < 17; i++) if (m[i]) p = i;
    m = (m << (23 - p)) & 32'h7FFFFF;
    return {h[15], 8'(p + 112), m[22:0]};
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Expected result of one sample under the current configuration.
  function automatic out_item_t convert_sample(in_item_t s);
    out_item_t r;
    r = '0;
    r.last_out = s.last_sample;
    case (fmt_q)
      FMT_FLOAT32: begin
        if (!dir_q) begin
          r.out_word_a = {float_to_q15(s.in_word_a), float_to_q15(s.in_word_b)};
        end else begin
          r.out_word_a = q15_to_float(s.in_word_a[31:16]);
          r.out_word_b = q15_to_float(s.in_word_a[15:0]);
        end
      end
      FMT_INT16: r.out_word_a = big_q ? s.in_word_a : swap_bytes(s.in_word_a);
      FMT_CUSTOM: r.out_word_a = s.in_word_a;
      default: r.format_error = 1'b1;
    endcase
    return r;
  endfunction

  // Random float bits, weighted toward the region where conversion matters.
  function automatic logic [31:0] random_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(9))
      0: f[30:23] = 8'h00;
      1: f[30:23] = 8'hFF;
      2: ;
      default: f[30:23] = 8'($urandom_range(140, 105));
    endcase
    return f;
  endfunction

  // Send one sample; the transfer is recorded with its predicted result.
  task automatic send_sample(logic [31:0] a, logic [31:0] b, logic last);
    in_item_t s;
    s.in_word_a = a;
    s.in_word_b = b;
    s.last_sample = last;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(convert_sample(s));
    sent_count++;
  endtask

  // Let the pipeline drain so the configuration can change safely.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [31:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIRECTION: dir_q = val[0];
      CFG_FORMAT: fmt_q = sample_format_e'(val[1:0]);
      CFG_HOST_BIG: big_q = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits of each value are random to show that only the low bits count.
  task automatic set_mode(logic dir, sample_format_e fmt, logic big);
    write_reg(CFG_DIRECTION, {8'($urandom_range(255)), 23'd0, dir});
    write_reg(CFG_FORMAT, ({$urandom()} & 32'hFFFF_FFFC) | 32'(fmt));
    write_reg(CFG_HOST_BIG, ({$urandom()} & 32'hFFFF_FFFE) | 32'(big));
  endtask

  // Result checker: compares every output transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        error_count++;
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        checked_count++;
        if (e.out_word_a !== out_data.out_word_a || e.out_word_b !== out_data.out_word_b ||
            e.last_out !== out_data.last_out || e.format_error !== out_data.format_error) begin
          $display("%0t: mismatch expected a=%h b=%h last=%b err=%b actual a=%h b=%h last=%b err=%b",
                   $realtime, e.out_word_a, e.out_word_b, e.last_out, e.format_error,
                   out_data.out_word_a, out_data.out_word_b, out_data.last_out,
                   out_data.format_error);
          error_count++;
        end
      end
    end
  end

  // Receiver readiness, forced low during a hold-off.
  always @(posedge clk) begin
    out_ready <= !hold_active && ($urandom_range(99) >= recv_idle);
  end

  // Hold-off of the receiver, counted in cycles.
  always begin
    @(hold_start);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (300) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Extremes of the fields, every format and the special float values.
  task automatic test_directed();
    set_mode(1'b0, FMT_FLOAT32, 1'b0);
    send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);  // both zeros
    send_sample(32'h3F80_0000, 32'hBF80_0000, 1'b1);  // +1 and -1 saturate
    send_sample(32'h7F80_0000, 32'hFF80_0000, 1'b0);  // infinities
    send_sample(32'h7FC0_0001, 32'hFFFF_FFFF, 1'b0);  // NaNs
    send_sample(32'h0000_0001, 32'h807F_FFFF, 1'b0);  // subnormals
    send_sample(32'h3F7F_FFFF, 32'hBF7F_FFFF, 1'b0);  // just below one
    send_sample(32'h3800_0000, 32'hB780_0000, 1'b1);  // 2^-15 and below
    send_sample(32'h3F00_0000, 32'hBF00_0000, 1'b0);
    set_mode(1'b1, FMT_FLOAT32, 1'b0);
    send_sample(32'h8000_7FFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0001_FFFF, 32'h0, 1'b1);
    send_sample(32'h0000_0000, 32'h0, 1'b0);
    set_mode(1'b0, FMT_INT16, 1'b0);
    send_sample(32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0, 1'b1);
    set_mode(1'b1, FMT_INT16, 1'b1);
    send_sample(32'h1234_5678, 32'h0, 1'b0);
    set_mode(1'b0, FMT_CUSTOM, 1'b0);
    send_sample(32'hDEAD_BEEF, 32'h1234_5678, 1'b1);
    set_mode(1'b1, FMT_UNSUP, 1'b1);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 32'h0, 1'b0);
    // A write to the unused index must change nothing.
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_sample(32'h0123_4567, 32'h0, 1'b1);
  endtask

  // Random samples over random modes, mostly float conversion.
  task automatic test_random(int unsigned n_items);
    int unsigned left;
    int unsigned run;
    left = n_items;
    while (left > 0) begin
      set_mode(1'($urandom()), sample_format_e'($urandom_range(5) < 3 ? 0 : $urandom_range(3)),
               1'($urandom()));
      run = $urandom_range(60, 20);
      if (run > left) run = left;
      repeat (run) begin
        logic [31:0] a;
        a = (fmt_q == FMT_FLOAT32 && !dir_q) ? random_float() : $urandom();
        send_sample(a, random_float(), ($urandom_range(7) == 0));
      end
      left -= run;
    end
  endtask

  // Long receiver hold-off while the sender keeps offering samples.
  task automatic test_backpressure();
    set_mode(1'b0, FMT_FLOAT32, 1'b0);
    -> hold_start;
    repeat (40) send_sample(random_float(), random_float(), 1'($urandom()));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 18;
    recv_idle = 49;
    test_random(550);
    send_idle = 49;
    recv_idle = 18;
    test_random(550);
    send_idle = 0;
    recv_idle = 0;
    test_backpressure();
    test_random(550);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered float, int16, pass-through and unsupported formats in both directions,");
    $display("%0d samples sent, %0d results checked, %0d errors.",
             sent_count, checked_count, error_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
